@@ rtl/core/tkpd_pkg.sv @@
// Shared widths, constants and types for the touch key press detector.
package tkpd_pkg;

	localparam int CH_W    = 3;
	localparam int COUNT_W = 16;
	localparam int THR_W   = 8;
	localparam int CAL_W   = 4;
	localparam int SEL_W   = 5;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd30;

	typedef struct packed {
		logic [COUNT_W-1:0] baseline;
		logic [CAL_W-1:0]   cal_cnt;
		logic               touched;
	} chan_state_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            calibrating;
		logic            touched;
		logic            press_event;
	} result_t;

endpackage

@@ rtl/core/tkpd_chan_bank.sv @@
// Per-channel state store: baseline, calibration count and touch flag.
module tkpd_chan_bank #(
	parameter int CHANNELS = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tkpd_pkg::CH_W-1:0]     sel,
	input  logic                          wr_en,
	input  tkpd_pkg::chan_state_t         wr_state,
	output logic                          hit,
	output tkpd_pkg::chan_state_t         rd_state
);

	tkpd_pkg::chan_state_t     state_q [CHANNELS];
	logic [CHANNELS-1:0]       match;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			match[i] = ({{(tkpd_pkg::SEL_W - tkpd_pkg::CH_W){1'b0}}, sel}
				== tkpd_pkg::SEL_W'(i));
		end
	end

	always_comb begin
		rd_state = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (match[i]) begin
				rd_state = rd_state | state_q[i];
			end
		end
	end

	assign hit = |match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (match[i]) begin
					state_q[i] <= wr_state;
				end
			end
		end
	end

endmodule

@@ rtl/core/tkpd_eval.sv @@
// Calibration and touch decision for one sample against its channel state.
module tkpd_eval #(
	parameter int CAL_ROUNDS = 10
) (
	input  logic [tkpd_pkg::CH_W-1:0]    channel,
	input  logic [tkpd_pkg::COUNT_W-1:0] measured_count,
	input  logic [tkpd_pkg::THR_W-1:0]   threshold,
	input  logic                         hit,
	input  tkpd_pkg::chan_state_t        cur_state,
	output tkpd_pkg::chan_state_t        nxt_state,
	output tkpd_pkg::result_t            result
);

	logic                           cal_active;
	logic [tkpd_pkg::COUNT_W:0]     base_sum;
	logic [tkpd_pkg::COUNT_W:0]     count_plus_thr;
	logic                           now_touched;

	assign cal_active     = cur_state.cal_cnt < tkpd_pkg::CAL_W'(CAL_ROUNDS);
	assign base_sum       = {1'b0, cur_state.baseline} + {1'b0, measured_count};
	assign count_plus_thr = {1'b0, measured_count}
		+ {{(tkpd_pkg::COUNT_W + 1 - tkpd_pkg::THR_W){1'b0}}, threshold};
	assign now_touched    = count_plus_thr < {1'b0, cur_state.baseline};

	always_comb begin
		nxt_state          = cur_state;
		result.channel     = channel;
		result.calibrating = 1'b0;
		result.touched     = 1'b0;
		result.press_event = 1'b0;
		if (hit) begin
			if (cal_active) begin
				// average the baseline towards the count
				nxt_state.baseline = base_sum[tkpd_pkg::COUNT_W:1];
				nxt_state.cal_cnt  = cur_state.cal_cnt + tkpd_pkg::CAL_W'(1);
				result.calibrating = 1'b1;
			end else begin
				nxt_state.touched  = now_touched;
				result.touched     = now_touched;
				result.press_event = now_touched && !cur_state.touched;
			end
		end
	end

endmodule

@@ rtl/core/touch_key_press_detector.sv @@
// Top level of the touch key press detector: input stage, state and result register.
//
// Usage: each item on the s_axis side carries one oscillator count for one
// touch channel. The block keeps a baseline per channel; the first
// CAL_ROUNDS samples of a channel average the baseline up from zero and are
// flagged as calibrating. After that, a sample counts as touched when
// count + threshold is below the baseline, and a press is flagged on the
// untouched-to-touched edge. Channels at or above CHANNELS give a result
// with all flags clear and change no state.
// The threshold is written over the cfg channel (always ready); the user must
// write it only while idle; the block does not enforce this. An item passes
// the input stage and then the result register. Throughput: one item per
// cycle while m_axis does not stall; the channel state is read, updated and
// written back in the same cycle as the result register loads, so a following
// sample of the same channel sees the update at once. Reset: all baselines,
// calibration counts and touch flags clear, the threshold returns to 30 and
// both stages empty. Stall: while m_axis_tready is low the result holds; the
// input stage then holds one further item before s_axis_tready drops.
module touch_key_press_detector #(
	parameter int CHANNELS   = 5,
	parameter int CAL_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [2:0] channel, [18:3] measured_count, rest zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [2:0] out_channel, [3] touched, [4] press_event
	output logic        m_axis_tuser,  // [0] calibrating
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // threshold
);

	logic                             valid_s1;
	logic [tkpd_pkg::CH_W-1:0]        channel_s1;
	logic [tkpd_pkg::COUNT_W-1:0]     count_s1;
	logic [tkpd_pkg::THR_W-1:0]       threshold_q;
	logic                             out_valid_q;
	tkpd_pkg::result_t                result_q;

	logic                             advance;
	logic                             take;
	logic                             hit;
	tkpd_pkg::chan_state_t            cur_state;
	tkpd_pkg::chan_state_t            nxt_state;
	tkpd_pkg::result_t                result;

	// the result register frees up when empty or being taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			channel_s1 <= s_axis_tdata[tkpd_pkg::CH_W-1:0];
			count_s1   <= s_axis_tdata[tkpd_pkg::CH_W +: tkpd_pkg::COUNT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tkpd_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	tkpd_chan_bank #(
		.CHANNELS (CHANNELS)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.sel      (channel_s1),
		.wr_en    (valid_s1 && advance),
		.wr_state (nxt_state),
		.hit      (hit),
		.rd_state (cur_state)
	);

	tkpd_eval #(
		.CAL_ROUNDS (CAL_ROUNDS)
	) u_eval (
		.channel        (channel_s1),
		.measured_count (count_s1),
		.threshold      (threshold_q),
		.hit            (hit),
		.cur_state      (cur_state),
		.nxt_state      (nxt_state),
		.result         (result)
	);

	// load the result as the state write-back happens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, result_q.press_event, result_q.touched, result_q.channel};
	assign m_axis_tuser  = result_q.calibrating;

endmodule

@@ rtl/core/tkpd_checker.sv @@
// Port-level checks for the touch key press detector, bound to the top level.
module tkpd_checker #(
	parameter int CHANNELS = 5
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser
);

	// hold a stalled result unchanged
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_cal_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[3] && !m_axis_tdata[4])
		else $error("touch reported during calibration");

	a_press_touch : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
		else $error("press without touch");

	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ({2'b00, m_axis_tdata[2:0]} >= 5'(CHANNELS)) |->
			!m_axis_tuser && !m_axis_tdata[3] && !m_axis_tdata[4])
		else $error("flags set for an unused channel");

endmodule

bind touch_key_press_detector tkpd_checker #(
	.CHANNELS (CHANNELS)
) u_tkpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
